// File: sv/rv32_pkg.sv
package rv32_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = $clog2(RF_DEPTH);

  localparam logic [15:0] SP_RESET  = 16'h3ffc;
  localparam logic [15:0] GP_RESET  = 16'h1800;
  localparam logic [15:0] DSS_RESET = 16'h2000;

  localparam logic [1:0] CFG_SP  = 2'd0;
  localparam logic [1:0] CFG_GP  = 2'd1;
  localparam logic [1:0] CFG_DSS = 2'd2;

  localparam logic [6:0] OPC_MASK   = 7'h7F;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_ALUR   = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [4:0] REG_SP = 5'd2;
  localparam logic [4:0] REG_GP = 5'd3;
  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  localparam logic [31:0] SVC_PRINT_INT = 32'd1;
  localparam logic [31:0] SVC_PRINT_STR = 32'd4;
  localparam logic [31:0] SVC_EXIT      = 32'd10;

  localparam logic [1:0] ECALL_NONE  = 2'd0;
  localparam logic [1:0] ECALL_INT   = 2'd1;
  localparam logic [1:0] ECALL_STR   = 2'd2;
  localparam logic [1:0] ECALL_EXIT  = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE_MEM = 3'd0,
    OP_READ_MEM  = 3'd1,
    OP_STEP      = 3'd2,
    OP_RESTART   = 3'd3,
    OP_READ_REG  = 3'd4
  } op_e_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HOST_WR, S_HOST_RD, S_HOST_RD_W, S_REG_RD, S_REG_RD_W,
    S_RESTART, S_RESTART2, S_FETCH, S_DECODE, S_EXEC, S_MEM_ACC, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] address;
    logic [31:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] program_counter;
    logic        halted;
    logic [1:0]  ecall_service;
    logic [31:0] ecall_argument;
    logic        illegal;
  } out_word_t;

endpackage

// File: sv/rv32i_instruction_step.sv
// RV32I integer core with its word memory and 32-entry register file inside.
// Each input word is one operation: write or read a memory word, read a
// register, restart, or step one instruction; each yields exactly one result
// word carrying the pc and halt flag after the operation. Items are handled one
// at a time. A step runs fetch read, register read, execute and result; loads
// and stores add a data memory read (stores merge and write back). Host memory
// and register reads issue the read and then capture it, a host write writes
// the word, restart writes sp and then gp, and a halted step or an unused
// operation goes straight to the result. Each memory read is registered and
// lies on the path of the next. A new word is taken once the result register
// is loaded. Memory contents are undefined until written; the register file
// reads zero until a register is written.
module rv32i_instruction_step
  import rv32_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration
  logic [15:0] sp_r, gp_r, dss_r;

  // control and architectural state
  state_t      state_r, state_nxt;
  in_word_t    item_r, item_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [31:0] ir_r, ir_nxt;
  logic        stopped_r, stopped_nxt;
  logic        fetch_ok_r, fetch_ok_nxt;
  logic        acc_ok_r, acc_ok_nxt;
  logic [1:0]  acc_addr_r, acc_addr_nxt;
  logic [MEM_AW-1:0] acc_idx_r, acc_idx_nxt;
  logic [31:0] st_data_r, st_data_nxt;
  logic [RF_DEPTH-1:0] rf_valid_r, rf_valid_nxt;
  out_word_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;
  logic        rfa_ok_r, rfb_ok_r;

  // memory ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [31:0]       mem_wdata, mem_rdata;
  logic              rf_we;
  logic [RF_AW-1:0]  rf_wa, rf_ra, rf_rb;
  logic [31:0]       rf_wd, rf_qa, rf_qb;

  rv32_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_addr), .wdata(mem_wdata),
    .raddr(mem_addr), .rdata(mem_rdata)
  );

  // two copies of the register file give two read ports
  rv32_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(rf_ra), .rdata(rf_qa)
  );

  rv32_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(rf_rb), .rdata(rf_qb)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decode helpers
  logic [31:0] ins, rs_a, rs_b, imm_i, imm_s, imm_b, imm_j, alu_y, alu_r;
  logic [31:0] ea, ld_w, ld_r, st_mask, st_val, host_addr, fetch_idx;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rd, shamt;
  logic        alt, take, br_ok, halted_now, ea_ok;
  logic [15:0] pc4;

  assign ins   = ir_r;
  assign opc   = ins[6:0] & OPC_MASK;
  assign f3    = ins[14:12];
  assign rd    = ins[11:7];
  assign alt   = (ins[31:25] == 7'h20);
  assign rs_a  = rfa_ok_r ? rf_qa : 32'd0;
  assign rs_b  = rfb_ok_r ? rf_qb : 32'd0;
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign pc4   = pc_r + 16'd4;
  assign halted_now = stopped_r || (pc_r >= dss_r);
  assign host_addr  = {20'd0, item_r.address};
  assign fetch_idx  = {18'd0, pc_r[15:2]};
  assign ea         = rs_a + ((opc == OPC_STORE) ? imm_s : imm_i);
  assign ea_ok      = ({2'b00, ea[31:2]} < 32'(MEM_WORDS));

  // ALU for immediate and register forms
  assign alu_y = (opc == OPC_ALUI) ? imm_i : rs_b;
  assign shamt = alu_y[4:0];
  always_comb begin
    case (f3)
      3'd0:    alu_r = (opc == OPC_ALUR && alt) ? rs_a - alu_y : rs_a + alu_y;
      3'd1:    alu_r = rs_a << shamt;
      3'd2:    alu_r = {31'd0, $signed(rs_a) < $signed(alu_y)};
      3'd3:    alu_r = {31'd0, rs_a < alu_y};
      3'd4:    alu_r = rs_a ^ alu_y;
      3'd5:    alu_r = alt ? 32'($signed(rs_a) >>> shamt) : rs_a >> shamt;
      3'd6:    alu_r = rs_a | alu_y;
      default: alu_r = rs_a & alu_y;
    endcase
  end

  // branch condition; the reserved codes are flagged illegal
  always_comb begin
    br_ok = 1'b1;
    case (f3)
      3'd0:    take = (rs_a == rs_b);
      3'd1:    take = (rs_a != rs_b);
      3'd4:    take = ($signed(rs_a) < $signed(rs_b));
      3'd5:    take = !($signed(rs_a) < $signed(rs_b));
      3'd6:    take = (rs_a < rs_b);
      3'd7:    take = (rs_a >= rs_b);
      default: begin
        take  = 1'b0;
        br_ok = 1'b0;
      end
    endcase
  end

  // load lane extraction from the word the data read returned
  assign ld_w = acc_ok_r ? mem_rdata : 32'd0;
  always_comb begin
    case (f3)
      3'd0:    ld_r = {{24{ld_w[{acc_addr_r, 3'd7}]}},
                       8'(ld_w >> {27'd0, acc_addr_r, 3'd0})};
      3'd1:    ld_r = {{16{ld_w[{acc_addr_r[1], 4'd15}]}},
                       16'(ld_w >> {27'd0, acc_addr_r[1], 4'd0})};
      3'd4:    ld_r = {24'd0, 8'(ld_w >> {27'd0, acc_addr_r, 3'd0})};
      3'd5:    ld_r = {16'd0, 16'(ld_w >> {27'd0, acc_addr_r[1], 4'd0})};
      default: ld_r = ld_w;
    endcase
  end

  // store lane mask and shifted data
  always_comb begin
    case (f3)
      3'd0: begin
        st_mask = 32'hFF << {27'd0, acc_addr_r, 3'd0};
        st_val  = st_data_r << {27'd0, acc_addr_r, 3'd0};
      end
      3'd1: begin
        st_mask = 32'hFFFF << {27'd0, acc_addr_r[1], 4'd0};
        st_val  = st_data_r << {27'd0, acc_addr_r[1], 4'd0};
      end
      default: begin
        st_mask = 32'hFFFF_FFFF;
        st_val  = st_data_r;
      end
    endcase
  end

  // jalr target bits 15..1
  function automatic logic [14:0] alu_sum_jalr(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return s[15:1];
  endfunction

  // sequencer: next state, memory ports and architectural updates
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pc_nxt        = pc_r;
    ir_nxt        = ir_r;
    stopped_nxt   = stopped_r;
    fetch_ok_nxt  = fetch_ok_r;
    acc_ok_nxt    = acc_ok_r;
    acc_addr_nxt  = acc_addr_r;
    acc_idx_nxt   = acc_idx_r;
    st_data_nxt   = st_data_r;
    rf_valid_nxt  = rf_valid_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = item_r.write_data;
    rf_we     = 1'b0;
    rf_wa     = '0;
    rf_wd     = '0;
    rf_ra     = '0;
    rf_rb     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          case (in_data.operation)
            OP_WRITE_MEM: state_nxt = S_HOST_WR;
            OP_READ_MEM:  state_nxt = S_HOST_RD;
            OP_STEP:      state_nxt = halted_now ? S_DONE : S_FETCH;
            OP_RESTART:   state_nxt = S_RESTART;
            OP_READ_REG:  state_nxt = S_REG_RD;
            default:      state_nxt = S_DONE;
          endcase
        end
      end

      S_HOST_WR: begin
        mem_addr  = host_addr[MEM_AW-1:0];
        mem_we    = (host_addr < 32'(MEM_WORDS));
        state_nxt = S_DONE;
      end

      S_HOST_RD: begin
        mem_addr   = host_addr[MEM_AW-1:0];
        acc_ok_nxt = (host_addr < 32'(MEM_WORDS));
        state_nxt  = S_HOST_RD_W;
      end

      S_HOST_RD_W: begin
        res_nxt.read_data = acc_ok_r ? mem_rdata : 32'd0;
        state_nxt = S_DONE;
      end

      S_REG_RD: begin
        rf_ra     = item_r.address[RF_AW-1:0];
        state_nxt = S_REG_RD_W;
      end

      S_REG_RD_W: begin
        res_nxt.read_data = rs_a;
        state_nxt = S_DONE;
      end

      S_RESTART: begin
        rf_we        = 1'b1;
        rf_wa        = REG_SP;
        rf_wd        = {16'd0, sp_r};
        rf_valid_nxt[REG_SP] = 1'b1;
        pc_nxt       = '0;
        ir_nxt       = '0;
        stopped_nxt  = 1'b0;
        state_nxt    = S_RESTART2;
      end

      S_RESTART2: begin
        rf_we        = 1'b1;
        rf_wa        = REG_GP;
        rf_wd        = {16'd0, gp_r};
        rf_valid_nxt[REG_GP] = 1'b1;
        state_nxt    = S_DONE;
      end

      S_FETCH: begin
        // out-of-range fetch reads as zero, an illegal word
        mem_addr     = fetch_idx[MEM_AW-1:0];
        fetch_ok_nxt = (fetch_idx < 32'(MEM_WORDS));
        state_nxt    = S_DECODE;
      end

      S_DECODE: begin
        ir_nxt = fetch_ok_r ? mem_rdata : 32'd0;
        if ((ir_nxt[6:0] & OPC_MASK) == OPC_SYSTEM) begin
          rf_ra = REG_A0;
          rf_rb = REG_A7;
        end else begin
          rf_ra = ir_nxt[19:15];
          rf_rb = ir_nxt[24:20];
        end
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        pc_nxt    = pc4;
        state_nxt = S_DONE;
        rf_wa     = rd;
        case (opc)
          OPC_LUI: begin
            rf_we = 1'b1;
            rf_wd = {ins[31:12], 12'd0};
          end
          OPC_AUIPC: begin
            rf_we = 1'b1;
            rf_wd = {16'd0, pc_r} + {ins[31:12], 12'd0};
          end
          OPC_JAL: begin
            rf_we  = 1'b1;
            rf_wd  = {16'd0, pc4};
            pc_nxt = pc_r + imm_j[15:0];
          end
          OPC_JALR: begin
            rf_we  = 1'b1;
            rf_wd  = {16'd0, pc4};
            pc_nxt = {alu_sum_jalr(rs_a, imm_i), 1'b0};
          end
          OPC_BRANCH: begin
            res_nxt.illegal = !br_ok;
            if (take) begin
              pc_nxt = pc_r + imm_b[15:0];
            end
          end
          OPC_LOAD: begin
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
              res_nxt.illegal = 1'b1;
            end else begin
              mem_addr     = ea[MEM_AW+1:2];
              acc_ok_nxt   = ea_ok;
              acc_addr_nxt = ea[1:0];
              acc_idx_nxt  = ea[MEM_AW+1:2];
              state_nxt    = S_MEM_ACC;
            end
          end
          OPC_STORE: begin
            if (f3 > 3'd2) begin
              res_nxt.illegal = 1'b1;
            end else begin
              mem_addr     = ea[MEM_AW+1:2];
              acc_ok_nxt   = ea_ok;
              acc_addr_nxt = ea[1:0];
              acc_idx_nxt  = ea[MEM_AW+1:2];
              st_data_nxt  = rs_b;
              state_nxt    = S_MEM_ACC;
            end
          end
          OPC_ALUI, OPC_ALUR: begin
            rf_we = 1'b1;
            rf_wd = alu_r;
          end
          OPC_SYSTEM: begin
            res_nxt.ecall_argument = rs_a;
            if (rs_b == SVC_PRINT_INT) begin
              res_nxt.ecall_service = ECALL_INT;
            end else if (rs_b == SVC_PRINT_STR) begin
              res_nxt.ecall_service = ECALL_STR;
            end else if (rs_b == SVC_EXIT) begin
              res_nxt.ecall_service = ECALL_EXIT;
              stopped_nxt = 1'b1;
            end else begin
              res_nxt.ecall_service = ECALL_NONE;
            end
          end
          default: res_nxt.illegal = 1'b1;
        endcase
        // drop writes to x0
        if (rd == 5'd0) begin
          rf_we = 1'b0;
        end
        if (rf_we) begin
          rf_valid_nxt[rd] = 1'b1;
        end
      end

      S_MEM_ACC: begin
        // hold the word index of the access issued in execute
        mem_addr = acc_idx_r;
        rf_wa    = rd;
        if (opc == OPC_LOAD) begin
          rf_we = (rd != 5'd0);
          rf_wd = ld_r;
          if (rf_we) begin
            rf_valid_nxt[rd] = 1'b1;
          end
        end else begin
          mem_we    = acc_ok_r;
          mem_wdata = (mem_rdata & ~st_mask) | (st_val & st_mask);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt                 = res_r;
          out_data_nxt.program_counter = pc_r;
          out_data_nxt.halted          = halted_now;
          out_valid_nxt                = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // register file validity of the two read addresses
  always_ff @(posedge clk) begin
    rfa_ok_r <= rf_valid_r[rf_ra];
    rfb_ok_r <= rf_valid_r[rf_rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      ir_r        <= '0;
      stopped_r   <= 1'b0;
      rf_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ir_r        <= ir_nxt;
      stopped_r   <= stopped_nxt;
      rf_valid_r  <= rf_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    fetch_ok_r <= fetch_ok_nxt;
    acc_ok_r   <= acc_ok_nxt;
    acc_addr_r <= acc_addr_nxt;
    acc_idx_r  <= acc_idx_nxt;
    st_data_r  <= st_data_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= SP_RESET;
      gp_r  <= GP_RESET;
      dss_r <= DSS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SP:  sp_r  <= cfg_wdata;
        CFG_GP:  gp_r  <= cfg_wdata;
        CFG_DSS: dss_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/rv32_ram.sv
module rv32_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/rv32i_step_checker.sv
`timescale 1ns / 1ps

module rv32i_step_checker
  import rv32_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fails,
  output int          pending
);

  logic [31:0] regs [RF_DEPTH];
  logic [31:0] mem [MEM_WORDS];
  logic [15:0] pc_q;
  logic        stopped_q;
  logic [15:0] sp_cfg, gp_cfg, dss_cfg;
  out_word_t   results_q [$];

  initial fails = 0;

  function automatic logic [31:0] mem_rd(logic [31:0] byte_a);
    logic [31:0] idx;
    idx = byte_a >> 2;
    return (idx < MEM_WORDS) ? mem[idx] : 32'd0;
  endfunction

  function automatic void mem_wr(logic [31:0] byte_a, logic [31:0] d, logic [31:0] m);
    logic [31:0] idx;
    idx = byte_a >> 2;
    if (idx < MEM_WORDS) mem[idx] = (mem[idx] & ~m) | (d & m);
  endfunction

  function automatic void put_reg(logic [4:0] rd, logic [31:0] v);
    if (rd != 5'd0) regs[rd] = v;
  endfunction

  // Execute one instruction; return 0 when it was not recognized.
  function automatic bit exec_instr(output logic [1:0] svc, output logic [31:0] arg);
    logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, ad, w, y, r;
    logic [15:0] pc;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd, sh, hs;
    logic        alt, take;
    svc = ECALL_NONE;
    arg = '0;
    pc = pc_q;
    ins = mem_rd({16'd0, pc});
    pc_q = pc + 16'd4;
    opc = ins[6:0];
    rd = ins[11:7];
    f3 = ins[14:12];
    alt = (ins[31:25] == 7'h20);
    a = regs[ins[19:15]];
    b = regs[ins[24:20]];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    case (opc)
      OPC_LUI: put_reg(rd, {ins[31:12], 12'd0});
      OPC_AUIPC: put_reg(rd, {16'd0, pc} + {ins[31:12], 12'd0});
      OPC_JAL: begin
        put_reg(rd, {16'd0, pc_q});
        r = {16'd0, pc} + imm_j;
        pc_q = r[15:0];
      end
      OPC_JALR: begin
        w = (a + imm_i) & ~32'd1;
        put_reg(rd, {16'd0, pc_q});
        pc_q = w[15:0];
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = ($signed(a) < $signed(b));
          3'd5: take = ($signed(a) >= $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: return 1'b0;
        endcase
        r = {16'd0, pc} + imm_b;
        if (take) pc_q = r[15:0];
      end
      OPC_LOAD: begin
        ad = a + imm_i;
        w = mem_rd(ad);
        sh = {ad[1:0], 3'b000};
        hs = sh & 5'd16;
        case (f3)
          3'd0: begin r = w >> sh; put_reg(rd, {{24{r[7]}}, r[7:0]}); end
          3'd1: begin r = w >> hs; put_reg(rd, {{16{r[15]}}, r[15:0]}); end
          3'd2: put_reg(rd, w);
          3'd4: put_reg(rd, (w >> sh) & 32'hFF);
          3'd5: put_reg(rd, (w >> hs) & 32'hFFFF);
          default: return 1'b0;
        endcase
      end
      OPC_STORE: begin
        ad = a + imm_s;
        sh = {ad[1:0], 3'b000};
        hs = sh & 5'd16;
        case (f3)
          3'd0: mem_wr(ad, b << sh, 32'hFF << sh);
          3'd1: mem_wr(ad, b << hs, 32'hFFFF << hs);
          3'd2: mem_wr(ad, b, 32'hFFFF_FFFF);
          default: return 1'b0;
        endcase
      end
      OPC_ALUI, OPC_ALUR: begin
        y = (opc == OPC_ALUI) ? imm_i : b;
        sh = y[4:0];
        case (f3)
          3'd0: r = (opc == OPC_ALUR && alt) ? a - y : a + y;
          3'd1: r = a << sh;
          3'd2: r = {31'd0, $signed(a) < $signed(y)};
          3'd3: r = {31'd0, a < y};
          3'd4: r = a ^ y;
          3'd5: r = alt ? 32'($signed(a) >>> sh) : a >> sh;
          3'd6: r = a | y;
          default: r = a & y;
        endcase
        put_reg(rd, r);
      end
      OPC_SYSTEM: begin
        arg = regs[REG_A0];
        case (regs[REG_A7])
          SVC_PRINT_INT: svc = ECALL_INT;
          SVC_PRINT_STR: svc = ECALL_STR;
          SVC_EXIT: begin svc = ECALL_EXIT; stopped_q = 1'b1; end
          default: svc = ECALL_NONE;
        endcase
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic out_word_t next_result(in_word_t w);
    out_word_t   o;
    logic [1:0]  svc;
    logic [31:0] arg;
    o = '0;
    svc = ECALL_NONE;
    arg = '0;
    case (w.operation)
      OP_WRITE_MEM: mem[w.address] = w.write_data;
      OP_READ_MEM:  o.read_data = mem[w.address];
      OP_STEP: begin
        // a halted core ignores the step
        if (!(stopped_q || pc_q >= dss_cfg)) o.illegal = !exec_instr(svc, arg);
      end
      OP_RESTART: begin
        pc_q = '0;
        stopped_q = 1'b0;
        regs[REG_SP] = {16'd0, sp_cfg};
        regs[REG_GP] = {16'd0, gp_cfg};
      end
      OP_READ_REG: o.read_data = regs[w.address[4:0]];
      default: ;
    endcase
    o.ecall_service = svc;
    o.ecall_argument = arg;
    o.program_counter = pc_q;
    o.halted = stopped_q || pc_q >= dss_cfg;
    return o;
  endfunction

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < RF_DEPTH; i++) regs[i] = '0;
      pc_q = '0;
      stopped_q = 1'b0;
      sp_cfg = SP_RESET;
      gp_cfg = GP_RESET;
      dss_cfg = DSS_RESET;
      results_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SP:  sp_cfg = cfg_wdata;
          CFG_GP:  gp_cfg = cfg_wdata;
          CFG_DSS: dss_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) results_q.push_back(next_result(in_data));
      if (out_valid && out_ready) begin
        if (results_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          fails++;
        end else begin
          e = results_q.pop_front();
          cmp_field("read_data", e.read_data, out_data.read_data);
          cmp_field("program_counter", e.program_counter, out_data.program_counter);
          cmp_field("halted", e.halted, out_data.halted);
          cmp_field("ecall_service", e.ecall_service, out_data.ecall_service);
          cmp_field("ecall_argument", e.ecall_argument, out_data.ecall_argument);
          cmp_field("illegal", e.illegal, out_data.illegal);
        end
      end
      pending <= results_q.size();
    end
  end

endmodule

// File: test/rv32i_instruction_step_tb.sv
`timescale 1ns / 1ps

module rv32i_instruction_step_tb;
  import rv32_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_WORDS = 150;

  // funct3 codes used by the program builders
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SP;
  logic [15:0] cfg_wdata = '0;

  int fails, pending;
  int idle_pct = 0, stall_pct = 0;
  int words_sent = 0, steps_sent = 0, phase_words = 0;
  int quiet = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rv32i_instruction_step dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  rv32i_step_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .fails, .pending
  );

  // Receiver stalls at random at the current phase's rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OPC_ALUR};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_u(logic [6:0] opc, logic [4:0] rd, logic [19:0] imm);
    return {imm, rd, opc};
  endfunction

  // Mostly low registers so that values get reused; now and then any.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(9) < 7) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  // Build a well-formed instruction of a random kind with random fields; a few
  // are raw words so that unknown opcodes and funct3 codes also show up.
  function automatic logic [31:0] rand_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [6:0]  f7;
    rd = 5'($urandom_range(31));
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3 = 3'($urandom_range(7));
    imm = 12'($urandom);
    case ($urandom_range(12))
      0: return enc_u(OPC_LUI, rd, 20'($urandom));
      1: return enc_u(OPC_AUIPC, rd, 20'($urandom));
      2: return enc_j(rd, 21'(($urandom_range(16) - 8) * 4));
      3: begin
        if ($urandom_range(3) != 0) rs1 = 5'd0;
        return enc_i(OPC_JALR, F3_ADD, rd, rs1, 12'($urandom_range(15) * 4 + $urandom_range(1)));
      end
      4: return enc_b(f3, rs1, rs2, 13'(($urandom_range(12) - 6) * 4));
      5: begin
        if ($urandom_range(1)) rs1 = $urandom_range(1) ? REG_GP : 5'd0;
        return enc_i(OPC_LOAD, f3, rd, rs1, imm);
      end
      6: begin
        if ($urandom_range(1)) rs1 = $urandom_range(1) ? REG_GP : 5'd0;
        return enc_s(3'($urandom_range(3)), rs1, rs2, imm);
      end
      7, 8: begin
        if (f3 == F3_SLL || f3 == F3_SR)
          imm = {($urandom_range(1) ? 7'h20 : 7'h00), 5'($urandom)};
        return enc_i(OPC_ALUI, f3, rd, rs1, imm);
      end
      9, 10: begin
        f7 = $urandom_range(1) ? 7'h20 : (($urandom_range(3) == 0) ? 7'($urandom) : 7'h00);
        return enc_r(f7, f3, rd, rs1, rs2);
      end
      11: begin
        // load a7 with a service code, or a0 with an argument
        if ($urandom_range(1)) begin
          case ($urandom_range(3))
            0: imm = SVC_PRINT_INT[11:0];
            1: imm = SVC_PRINT_STR[11:0];
            2: imm = SVC_EXIT[11:0];
            default: ;
          endcase
          return enc_i(OPC_ALUI, F3_ADD, REG_A7, 5'd0, imm);
        end
        return enc_i(OPC_ALUI, F3_ADD, REG_A0, rs1, imm);
      end
      default: begin
        if ($urandom_range(3) == 0) return $urandom;
        return {25'($urandom), OPC_SYSTEM};
      end
    endcase
  endfunction

  // Offer one word, hold it until accepted; maybe idle first.
  task automatic send(logic [2:0] op, logic [11:0] addr, logic [31:0] data);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_data <= '{operation: op, address: addr, write_data: data};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    phase_words++;
    if (op == OP_STEP) steps_sent++;
  endtask

  // Hold the sender until every expected result is in, then let the core settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [15:0] sp, logic [15:0] gp, logic [15:0] dss);
    logic [15:0] v [3];
    v = '{sp, gp, dss};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Directed program: sign and shift corners, byte/halfword access, taken
  // branch, jal, jalr with an odd target, an unknown word, ecall and exit.
  task automatic run_directed();
    logic [31:0] prog [21];
    prog = '{
      enc_u(OPC_LUI, 5'd5, 20'h80000),
      enc_i(OPC_ALUI, F3_ADD, 5'd6, 5'd0, 12'hFFF),
      enc_i(OPC_ALUI, F3_SR, 5'd7, 5'd5, 12'h404),
      enc_r(7'h20, F3_ADD, 5'd8, 5'd0, 5'd6),
      enc_r(7'h00, F3_SLT, 5'd9, 5'd5, 5'd6),
      enc_i(OPC_ALUI, F3_SLTU, 5'd9, 5'd6, 12'd1),
      enc_r(7'h00, F3_SLL, 5'd11, 5'd6, 5'd8),
      enc_s(F3_SH, REG_GP, 5'd6, 12'd2),
      enc_i(OPC_LOAD, F3_LBU, 5'd12, REG_GP, 12'd3),
      enc_b(F3_BLT, 5'd5, 5'd6, 13'd8),
      32'hFFFF_FFFF,
      enc_j(5'd1, 21'd8),
      32'h0,
      enc_u(OPC_AUIPC, 5'd13, 20'h12345),
      enc_i(OPC_JALR, F3_ADD, 5'd14, 5'd0, 12'd65),
      32'h0,
      32'hFFFF_FFFF,
      enc_i(OPC_ALUI, F3_ADD, REG_A7, 5'd0, SVC_PRINT_INT[11:0]),
      {25'd0, OPC_SYSTEM},
      enc_i(OPC_ALUI, F3_ADD, REG_A7, 5'd0, SVC_EXIT[11:0]),
      {25'd0, OPC_SYSTEM}
    };
    for (int i = 0; i < 21; i++) send(OP_WRITE_MEM, 12'(i), prog[i]);
    send(OP_RESTART, 12'd0, 32'd0);
    for (int i = 0; i < 18; i++) send(OP_STEP, 12'd0, 32'd0);
    send(OP_READ_REG, 12'd31, 32'd0);
    send(3'd7, 12'hFFF, 32'hFFFF_FFFF);
  endtask

  // Load a short random program at word 0, restart, and run it with host
  // traffic and the odd stray word mixed in.
  task automatic run_program();
    int n, m, r;
    n = $urandom_range(4, 14);
    for (int k = 0; k < n; k++) send(OP_WRITE_MEM, 12'(k), rand_instr());
    send(OP_RESTART, 12'($urandom), $urandom);
    m = $urandom_range(n, n + 10);
    for (int k = 0; k < m; k++) begin
      r = $urandom_range(99);
      if (r < 78) send(OP_STEP, 12'($urandom), $urandom);
      else if (r < 87) send(OP_READ_REG, 12'($urandom), $urandom);
      else if (r < 93) send(OP_READ_MEM, 12'($urandom), $urandom);
      else if (r < 96) send(OP_WRITE_MEM, 12'($urandom), $urandom);
      else if (r < 98) send(3'($urandom_range(5, 7)), 12'($urandom), $urandom);
      else send(OP_RESTART, 12'($urandom), $urandom);
    end
    if ($urandom_range(7) == 0) drain();
  endtask

  initial begin
    int idle_tab [4], stall_tab [4];
    idle_tab = '{0, 51, 0, 23};
    stall_tab = '{0, 0, 51, 23};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Define every memory word before anything can read it.
    for (int i = 0; i < MEM_WORDS; i++) send(OP_WRITE_MEM, 12'(i), 32'd0);
    run_directed();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_cfg(SP_RESET, GP_RESET, DSS_RESET);
        1: write_cfg(16'd0, 16'd0, 16'd0);
        2: write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: write_cfg(16'($urandom), 16'($urandom), 16'd40);
        default: write_cfg(16'($urandom), 16'($urandom),
                           $urandom_range(1) ? DSS_RESET : 16'($urandom_range(24, 200)));
      endcase
      idle_pct = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      phase_words = 0;
      while (phase_words < PHASE_WORDS) run_program();
    end

    drain();
    $display("Sent %0d words (%0d steps) through eight phases of config and idling,",
             words_sent, steps_sent);
    $display("covering random programs, host traffic, restarts and halts.");
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rv32_pkg.sv
sv/rv32_ram.sv
sv/rv32i_instruction_step.sv
test/rv32i_step_checker.sv
test/rv32i_instruction_step_tb.sv
